/* rtl/nbbw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_pkg
// Shared widths, limits and stage types of the net bounding-box wirelength core.
// ----------------------------------------------------------------------------
package nbbw_pkg;

	localparam int CELL_INDEX_BITS_DEF = 16;
	localparam int POSITION_BITS_DEF   = 32;
	localparam int OFFSET_BITS         = 21;
	localparam int WEIGHT_BITS         = 16;
	localparam int COST_BITS           = 50;
	localparam int TOTAL_BITS          = 63;
	localparam int OUT_INDEX_BITS      = 16;

	localparam logic [COST_BITS-1:0]  COST_MAX  = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	// Bounds hold a position plus an offset, and the difference of two bounds.
	function automatic int bound_bits(input int pos_bits);
		return ((pos_bits > OFFSET_BITS) ? pos_bits : OFFSET_BITS) + 2;
	endfunction

	// Extreme owners as they leave the block.
	typedef struct packed {
		logic [OUT_INDEX_BITS-1:0] low_index;
		logic                      low_found;
		logic [OUT_INDEX_BITS-1:0] high_index;
		logic                      high_found;
	} owner_t;

	// Control that travels with each beat down the pipeline.
	typedef struct packed {
		logic valid;
		logic clear;
	} stage_ctl_t;

endpackage

/* rtl/nbbw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_if
// Valid/ready channels: pin beats in, net result beats out.
// ----------------------------------------------------------------------------
interface nbbw_pin_if #(
	parameter int POSITION_BITS   = nbbw_pkg::POSITION_BITS_DEF,
	parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF
);
	logic                                   valid;
	logic                                   ready;
	logic signed [POSITION_BITS-1:0]        cell_position;
	logic [CELL_INDEX_BITS-1:0]             cell_index;
	logic signed [nbbw_pkg::OFFSET_BITS-1:0] pin_low_offset;
	logic signed [nbbw_pkg::OFFSET_BITS-1:0] pin_high_offset;
	logic                                   has_pin;
	logic                                   first_of_net;
	logic                                   last_of_net;
	logic signed [POSITION_BITS-1:0]        net_low_bound;
	logic signed [POSITION_BITS-1:0]        net_high_bound;
	logic [nbbw_pkg::WEIGHT_BITS-1:0]       net_weight;
	logic                                   first_of_pass;

	modport source (
		output valid, cell_position, cell_index, pin_low_offset, pin_high_offset,
		has_pin, first_of_net, last_of_net, net_low_bound, net_high_bound,
		net_weight, first_of_pass,
		input  ready
	);
	modport sink (
		input  valid, cell_position, cell_index, pin_low_offset, pin_high_offset,
		has_pin, first_of_net, last_of_net, net_low_bound, net_high_bound,
		net_weight, first_of_pass,
		output ready
	);
endinterface

interface nbbw_cost_if;
	logic                                valid;
	logic                                ready;
	logic [nbbw_pkg::COST_BITS-1:0]      net_cost;
	logic [nbbw_pkg::TOTAL_BITS-1:0]     running_total;
	logic [nbbw_pkg::OUT_INDEX_BITS-1:0] low_cell_index;
	logic                                low_found;
	logic [nbbw_pkg::OUT_INDEX_BITS-1:0] high_cell_index;
	logic                                high_found;

	modport source (
		output valid, net_cost, running_total, low_cell_index, low_found,
		high_cell_index, high_found,
		input  ready
	);
	modport sink (
		input  valid, net_cost, running_total, low_cell_index, low_found,
		high_cell_index, high_found,
		output ready
	);
endinterface

/* rtl/nbbw_bound_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_bound_tracker
// Running low/high bounds per net; hands finished nets to stage 1.
// ----------------------------------------------------------------------------
module nbbw_bound_tracker #(
	parameter int POSITION_BITS   = nbbw_pkg::POSITION_BITS_DEF,
	parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	nbbw_pin_if.sink                                 pins,
	input  logic                                     dn_ready,
	output nbbw_pkg::stage_ctl_t                     ctl_s1,
	output logic signed [nbbw_pkg::bound_bits(POSITION_BITS)-1:0] low_s1,
	output logic signed [nbbw_pkg::bound_bits(POSITION_BITS)-1:0] high_s1,
	output logic [nbbw_pkg::WEIGHT_BITS-1:0]         weight_s1,
	output nbbw_pkg::owner_t                         owner_s1
);

	localparam int BOUND_BITS = nbbw_pkg::bound_bits(POSITION_BITS);

	logic signed [BOUND_BITS-1:0]       cur_low_q, cur_high_q;
	logic [CELL_INDEX_BITS-1:0]         low_owner_q, high_owner_q;
	logic                               low_valid_q, high_valid_q;
	logic [nbbw_pkg::WEIGHT_BITS-1:0]   weight_q;
	logic                               clear_pend_q;

	logic signed [BOUND_BITS-1:0]       seed_low, seed_high, lo_edge, hi_edge;
	logic signed [BOUND_BITS-1:0]       nxt_low, nxt_high;
	logic [CELL_INDEX_BITS-1:0]         nxt_low_own, nxt_high_own;
	logic                               nxt_low_valid, nxt_high_valid;
	logic [nbbw_pkg::WEIGHT_BITS-1:0]   nxt_weight;
	logic                               take_low, take_high, accept;

	assign pins.ready = !ctl_s1.valid || dn_ready;
	assign accept     = pins.valid && pins.ready;

	// Seed from the fixed extent on the first beat, then widen strictly.
	always_comb begin
		seed_low  = pins.first_of_net ? BOUND_BITS'(pins.net_low_bound)  : cur_low_q;
		seed_high = pins.first_of_net ? BOUND_BITS'(pins.net_high_bound) : cur_high_q;
		lo_edge   = BOUND_BITS'(pins.cell_position) + BOUND_BITS'(pins.pin_low_offset);
		hi_edge   = BOUND_BITS'(pins.cell_position) + BOUND_BITS'(pins.pin_high_offset);
		take_low  = pins.has_pin && (lo_edge < seed_low);
		take_high = pins.has_pin && (hi_edge > seed_high);

		nxt_low        = take_low ? lo_edge : seed_low;
		nxt_high       = take_high ? hi_edge : seed_high;
		nxt_low_own    = take_low ? pins.cell_index
			: (pins.first_of_net ? '0 : low_owner_q);
		nxt_high_own   = take_high ? pins.cell_index
			: (pins.first_of_net ? '0 : high_owner_q);
		nxt_low_valid  = take_low || (!pins.first_of_net && low_valid_q);
		nxt_high_valid = take_high || (!pins.first_of_net && high_valid_q);
		nxt_weight     = pins.first_of_net ? pins.net_weight : weight_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_low_q    <= '0;
			cur_high_q   <= '0;
			low_owner_q  <= '0;
			high_owner_q <= '0;
			low_valid_q  <= 1'b0;
			high_valid_q <= 1'b0;
			weight_q     <= '0;
			clear_pend_q <= 1'b0;
			ctl_s1       <= '0;
		end else begin
			if (accept) begin
				cur_low_q    <= nxt_low;
				cur_high_q   <= nxt_high;
				low_owner_q  <= nxt_low_own;
				high_owner_q <= nxt_high_own;
				low_valid_q  <= nxt_low_valid;
				high_valid_q <= nxt_high_valid;
				weight_q     <= nxt_weight;
			end
			if (accept && pins.last_of_net) begin
				ctl_s1.valid <= 1'b1;
				ctl_s1.clear <= pins.first_of_pass || clear_pend_q;
				clear_pend_q <= 1'b0;
			end else begin
				if (dn_ready) begin
					ctl_s1.valid <= 1'b0;
				end
				if (accept && pins.first_of_pass) begin
					clear_pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pins.last_of_net) begin
			low_s1              <= nxt_low;
			high_s1             <= nxt_high;
			weight_s1           <= nxt_weight;
			owner_s1.low_index  <= nxt_low_valid
				? nbbw_pkg::OUT_INDEX_BITS'(nxt_low_own) : '0;
			owner_s1.low_found  <= nxt_low_valid;
			owner_s1.high_index <= nxt_high_valid
				? nbbw_pkg::OUT_INDEX_BITS'(nxt_high_own) : '0;
			owner_s1.high_found <= nxt_high_valid;
		end
	end

endmodule

/* rtl/nbbw_cost_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_cost_unit
// Span of the net (stage 2), weighted and saturated cost (stage 3).
// ----------------------------------------------------------------------------
module nbbw_cost_unit #(
	parameter int POSITION_BITS = nbbw_pkg::POSITION_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  nbbw_pkg::stage_ctl_t                     ctl_s1,
	input  logic signed [nbbw_pkg::bound_bits(POSITION_BITS)-1:0] low_s1,
	input  logic signed [nbbw_pkg::bound_bits(POSITION_BITS)-1:0] high_s1,
	input  logic [nbbw_pkg::WEIGHT_BITS-1:0]         weight_s1,
	input  nbbw_pkg::owner_t                         owner_s1,
	output logic                                     up_ready,
	input  logic                                     dn_ready,
	output nbbw_pkg::stage_ctl_t                     ctl_s3,
	output logic [nbbw_pkg::COST_BITS-1:0]           cost_s3,
	output nbbw_pkg::owner_t                         owner_s3
);

	localparam int BOUND_BITS = nbbw_pkg::bound_bits(POSITION_BITS);
	localparam int PROD_BITS  = BOUND_BITS + nbbw_pkg::WEIGHT_BITS;
	localparam int WIDE_BITS  = (PROD_BITS > nbbw_pkg::COST_BITS)
		? PROD_BITS : nbbw_pkg::COST_BITS;

	nbbw_pkg::stage_ctl_t               ctl_s2;
	logic [BOUND_BITS-1:0]              span_s2;
	logic [nbbw_pkg::WEIGHT_BITS-1:0]   weight_s2;
	nbbw_pkg::owner_t                   owner_s2;

	logic signed [BOUND_BITS:0]         diff;
	logic [PROD_BITS-1:0]               product;
	logic [WIDE_BITS-1:0]               prod_wide;
	logic                               ready_s3;

	assign ready_s3 = !ctl_s3.valid || dn_ready;
	assign up_ready = !ctl_s2.valid || ready_s3;

	// A span that is zero or negative costs nothing.
	assign diff      = (BOUND_BITS + 1)'(high_s1) - (BOUND_BITS + 1)'(low_s1);
	assign product   = PROD_BITS'(span_s2) * PROD_BITS'(weight_s2);
	assign prod_wide = WIDE_BITS'(product);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (up_ready) begin
				ctl_s2 <= ctl_s1;
			end
			if (ready_s3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			span_s2   <= (diff > 0) ? diff[BOUND_BITS-1:0] : '0;
			weight_s2 <= weight_s1;
			owner_s2  <= owner_s1;
		end
		if (ready_s3) begin
			cost_s3  <= (prod_wide > WIDE_BITS'(nbbw_pkg::COST_MAX))
				? nbbw_pkg::COST_MAX : nbbw_pkg::COST_BITS'(prod_wide);
			owner_s3 <= owner_s2;
		end
	end

endmodule

/* rtl/nbbw_total_acc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_total_acc
// Saturating pass total and the output register (stage 4).
// ----------------------------------------------------------------------------
module nbbw_total_acc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nbbw_pkg::stage_ctl_t           ctl_s3,
	input  logic [nbbw_pkg::COST_BITS-1:0] cost_s3,
	input  nbbw_pkg::owner_t               owner_s3,
	output logic                           up_ready,
	nbbw_cost_if.source                    costs
);

	localparam int TB = nbbw_pkg::TOTAL_BITS;

	logic [TB-1:0]                  total_q;
	logic                           valid_s4;
	logic [nbbw_pkg::COST_BITS-1:0] cost_s4;
	nbbw_pkg::owner_t               owner_s4;

	logic [TB-1:0]                  base;
	logic [TB:0]                    sum;
	logic [TB-1:0]                  nxt_total;
	logic                           advance;

	assign up_ready = !valid_s4 || costs.ready;
	assign advance  = ctl_s3.valid && up_ready;

	// Clear first, then add; pin at the top on overflow.
	assign base      = ctl_s3.clear ? '0 : total_q;
	assign sum       = (TB + 1)'(base) + (TB + 1)'(cost_s3);
	assign nxt_total = (sum > (TB + 1)'(nbbw_pkg::TOTAL_MAX))
		? nbbw_pkg::TOTAL_MAX : sum[TB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			valid_s4 <= 1'b0;
		end else begin
			if (advance) begin
				total_q <= nxt_total;
			end
			if (up_ready) begin
				valid_s4 <= ctl_s3.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cost_s4  <= cost_s3;
			owner_s4 <= owner_s3;
		end
	end

	assign costs.valid           = valid_s4;
	assign costs.net_cost        = cost_s4;
	assign costs.running_total   = total_q;
	assign costs.low_cell_index  = owner_s4.low_index;
	assign costs.low_found       = owner_s4.low_found;
	assign costs.high_cell_index = owner_s4.high_index;
	assign costs.high_found      = owner_s4.high_found;

endmodule

/* rtl/net_bounding_box_wirelength_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_bounding_box_wirelength_core
// Half-perimeter wirelength along one axis for pins streamed net by net.
// ----------------------------------------------------------------------------
// Pin beats arrive on pins, grouped by net: first_of_net seeds the bounds from
// the net's fixed extent and latches its Q8.8 weight, each beat with has_pin
// widens the bounds by strict compare and records the owning cell, and
// last_of_net produces one result beat on costs, which passes through the
// bounds register, span, weighted cost, then saturating total in the output
// register. The core takes one pin beat every cycle while pins.ready is
// high; that rate is set by the bound compare-and-update loop, which closes
// on the running bounds registers. A finished result waits in the output
// register while new pins keep flowing, up to four nets in flight;
// backpressure on costs reaches pins only once every stage is full.
// first_of_pass on any beat clears the running total before the next net's
// cost is added. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module net_bounding_box_wirelength_core #(
	parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF,
	parameter int POSITION_BITS   = nbbw_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nbbw_pin_if.sink    pins,
	nbbw_cost_if.source costs
);

	localparam int BOUND_BITS = nbbw_pkg::bound_bits(POSITION_BITS);

	// Stage 1: bounds of a finished net.
	nbbw_pkg::stage_ctl_t             ctl_s1;
	logic signed [BOUND_BITS-1:0]     low_s1, high_s1;
	logic [nbbw_pkg::WEIGHT_BITS-1:0] weight_s1;
	nbbw_pkg::owner_t                 owner_s1;
	logic                             ready_s2;

	// Stage 3: weighted cost.
	nbbw_pkg::stage_ctl_t             ctl_s3;
	logic [nbbw_pkg::COST_BITS-1:0]   cost_s3;
	nbbw_pkg::owner_t                 owner_s3;
	logic                             ready_s4;

	// Track the running extremes; hand each finished net on.
	nbbw_bound_tracker #(
		.POSITION_BITS   (POSITION_BITS),
		.CELL_INDEX_BITS (CELL_INDEX_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pins      (pins),
		.dn_ready  (ready_s2),
		.ctl_s1    (ctl_s1),
		.low_s1    (low_s1),
		.high_s1   (high_s1),
		.weight_s1 (weight_s1),
		.owner_s1  (owner_s1)
	);

	// Subtract the bounds, then multiply by the weight and saturate.
	nbbw_cost_unit #(
		.POSITION_BITS (POSITION_BITS)
	) u_cost (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.low_s1    (low_s1),
		.high_s1   (high_s1),
		.weight_s1 (weight_s1),
		.owner_s1  (owner_s1),
		.up_ready  (ready_s2),
		.dn_ready  (ready_s4),
		.ctl_s3    (ctl_s3),
		.cost_s3   (cost_s3),
		.owner_s3  (owner_s3)
	);

	// Accumulate the pass total and hold the result beat.
	nbbw_total_acc u_total (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.cost_s3  (cost_s3),
		.owner_s3 (owner_s3),
		.up_ready (ready_s4),
		.costs    (costs)
	);

endmodule

/* rtl/nbbw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbw_checker
// Port-level checks on result beats of the wirelength core.
// ----------------------------------------------------------------------------
module nbbw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [nbbw_pkg::COST_BITS-1:0]      net_cost,
	input logic [nbbw_pkg::TOTAL_BITS-1:0]     running_total,
	input logic [nbbw_pkg::OUT_INDEX_BITS-1:0] low_cell_index,
	input logic                                low_found,
	input logic [nbbw_pkg::OUT_INDEX_BITS-1:0] high_cell_index,
	input logic                                high_found
);

	// Hold a stalled result beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(net_cost) && $stable(running_total)
			&& $stable(low_cell_index) && $stable(high_cell_index)
			&& $stable(low_found) && $stable(high_found))
		else $error("result payload changed while stalled");

	// An extreme that no movable pin set reports cell zero.
	a_owner_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (low_found || low_cell_index == '0)
			&& (high_found || high_cell_index == '0))
		else $error("cell index reported without found flag");

	// The total already includes this net's cost.
	a_total_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> running_total >= nbbw_pkg::TOTAL_BITS'(net_cost))
		else $error("running total below net cost");

endmodule

bind net_bounding_box_wirelength_core nbbw_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (costs.valid),
	.out_ready       (costs.ready),
	.net_cost        (costs.net_cost),
	.running_total   (costs.running_total),
	.low_cell_index  (costs.low_cell_index),
	.low_found       (costs.low_found),
	.high_cell_index (costs.high_cell_index),
	.high_found      (costs.high_found)
);

/* dv/net_bounding_box_wirelength_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_bounding_box_wirelength_core_tb
// Self-checking bench for the one-axis half-perimeter wirelength core.
// ----------------------------------------------------------------------------
// A directed pass walks a stimulus table first. It covers reset state, strict
// ties, negative spans, field extremes and clearing of the pass total. A
// random pass of well-formed nets follows, with flag noise mixed in.
// A behavioral predictor tracks the bounding box of every accepted pin beat.
// It queues one expected result per net, and the sink side checks each result
// beat field by field.
// ----------------------------------------------------------------------------
module net_bounding_box_wirelength_core_tb;

	localparam int PW = nbbw_pkg::POSITION_BITS_DEF;
	localparam int CW = nbbw_pkg::CELL_INDEX_BITS_DEF;
	localparam int OW = nbbw_pkg::OFFSET_BITS;
	localparam int WB = nbbw_pkg::WEIGHT_BITS;
	localparam int CB = nbbw_pkg::COST_BITS;
	localparam int TW = nbbw_pkg::TOTAL_BITS;
	localparam int IW = nbbw_pkg::OUT_INDEX_BITS;
	localparam int BW = PW + 2;            // bound width: position + offset, then a difference
	localparam int RANDOM_ITEMS     = 820;
	localparam int LONG_HOLD_AT     = 40;    // sink beat index where the long hold-off starts
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 16;

	typedef struct packed {
		logic signed [PW-1:0] position;
		logic [CW-1:0]        cell_id;
		logic signed [OW-1:0] off_lo;
		logic signed [OW-1:0] off_hi;
		logic                 has_pin;
		logic                 first_net;
		logic                 last_net;
		logic signed [PW-1:0] bound_lo;
		logic signed [PW-1:0] bound_hi;
		logic [WB-1:0]        weight;
		logic                 first_pass;
	} pin_beat_t;

	typedef struct packed {
		logic [CB-1:0] cost;
		logic [TW-1:0] total;
		logic [IW-1:0] low_cell;
		logic          low_found;
		logic [IW-1:0] high_cell;
		logic          high_found;
	} net_cost_t;

	// One directed row: the beat, and a hand-typed result where one is obvious.
	typedef struct packed {
		pin_beat_t beat;
		logic      typed;
		net_cost_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nbbw_pin_if  pin_ch ();
	nbbw_cost_if cost_ch ();

	net_bounding_box_wirelength_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pins   (pin_ch),
		.costs  (cost_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predicted bounding-box state, mirrors the core after reset.
	logic signed [BW-1:0] box_lo   = '0;
	logic signed [BW-1:0] box_hi   = '0;
	logic [CW-1:0]        lo_cell  = '0;
	logic [CW-1:0]        hi_cell  = '0;
	logic                 lo_hit   = 1'b0;
	logic                 hi_hit   = 1'b0;
	logic [WB-1:0]        net_wt   = '0;
	logic [TW-1:0]        pass_sum = '0;

	net_cost_t cost_expected_q [$];
	int  pending      = 0;
	int  miss_count   = 0;
	int  beats_sent   = 0;
	int  beats_taken  = 0;
	bit  quiet_source = 1'b0;   // stretch of back-to-back pin beats
	bit  quiet_sink   = 1'b0;   // stretch of ready held high

	task automatic log_miss(input string detail);
		$display("[tb] mismatch: %s", detail);
		miss_count++;
	endtask

	// Advance the predicted box by one accepted beat; return the net result on last.
	task automatic step_bounding_box(input pin_beat_t b, output bit emits, output net_cost_t r);
		logic signed [PW-1:0] p;
		logic signed [OW-1:0] olo;
		logic signed [OW-1:0] ohi;
		logic signed [PW-1:0] nlo;
		logic signed [PW-1:0] nhi;
		logic signed [BW-1:0] lo_edge;
		logic signed [BW-1:0] hi_edge;
		logic [BW-1:0]        span;
		logic [BW+WB:0]       prod;
		logic [CB-1:0]        cost;
		logic [63:0]          sum;
		p   = b.position;
		olo = b.off_lo;
		ohi = b.off_hi;
		nlo = b.bound_lo;
		nhi = b.bound_hi;
		r = '0;
		// clear the total before this beat's net can add to it
		if (b.first_pass) begin
			pass_sum = '0;
		end
		// seed from the fixed extent before the pin of the same beat is compared
		if (b.first_net) begin
			box_lo  = nlo;
			box_hi  = nhi;
			lo_cell = '0;
			hi_cell = '0;
			lo_hit  = 1'b0;
			hi_hit  = 1'b0;
			net_wt  = b.weight;
		end
		// widen only on a strict improvement
		if (b.has_pin) begin
			lo_edge = p + olo;
			hi_edge = p + ohi;
			if (lo_edge < box_lo) begin
				box_lo  = lo_edge;
				lo_cell = b.cell_id;
				lo_hit  = 1'b1;
			end
			if (hi_edge > box_hi) begin
				box_hi  = hi_edge;
				hi_cell = b.cell_id;
				hi_hit  = 1'b1;
			end
		end
		emits = b.last_net;
		if (!emits) begin
			return;
		end
		cost = '0;
		if (box_hi > box_lo) begin
			span = box_hi - box_lo;
			prod = span * net_wt;
			cost = (prod > nbbw_pkg::COST_MAX) ? nbbw_pkg::COST_MAX : prod[CB-1:0];
		end
		sum = 64'(pass_sum) + 64'(cost);
		pass_sum = (sum > 64'(nbbw_pkg::TOTAL_MAX)) ? nbbw_pkg::TOTAL_MAX : sum[TW-1:0];
		r.cost       = cost;
		r.total      = pass_sum;
		r.low_cell   = lo_hit ? IW'(lo_cell) : '0;
		r.low_found  = lo_hit;
		r.high_cell  = hi_hit ? IW'(hi_cell) : '0;
		r.high_found = hi_hit;
	endtask

	function automatic logic signed [PW-1:0] rand_position();
		case ($urandom_range(0, 7))
			0:       return {1'b1, {(PW-1){1'b0}}};
			1:       return {1'b0, {(PW-1){1'b1}}};
			2, 3:    return PW'($signed($urandom_range(0, 2000)) - 1000);
			default: return PW'($urandom);
		endcase
	endfunction

	function automatic logic signed [OW-1:0] rand_offset();
		case ($urandom_range(0, 7))
			0:       return {1'b1, {(OW-1){1'b0}}};
			1:       return {1'b0, {(OW-1){1'b1}}};
			2:       return '0;
			3, 4:    return OW'($signed($urandom_range(0, 40)) - 20);
			default: return OW'($urandom);
		endcase
	endfunction

	function automatic logic [WB-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 16'h0100;
			default: return WB'($urandom);
		endcase
	endfunction

	// Every field random, flags included; nets override the flags.
	function automatic pin_beat_t random_beat();
		pin_beat_t b;
		b.position   = rand_position();
		b.cell_id    = CW'($urandom);
		b.off_lo     = rand_offset();
		b.off_hi     = rand_offset();
		b.has_pin    = 1'($urandom);
		b.first_net  = 1'($urandom);
		b.last_net   = 1'($urandom);
		b.bound_lo   = rand_position();
		b.bound_hi   = rand_position();
		b.weight     = rand_weight();
		b.first_pass = 1'($urandom);
		return b;
	endfunction

	// Offer one pin beat after a random gap, hold it until accepted, then predict.
	task automatic offer_beat(input pin_beat_t b, input logic use_typed, input net_cost_t typed_want);
		int        gap;
		bit        emits;
		net_cost_t predicted;
		gap = quiet_source ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			pin_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin_ch.cell_position   <= b.position;
		pin_ch.cell_index      <= b.cell_id;
		pin_ch.pin_low_offset  <= b.off_lo;
		pin_ch.pin_high_offset <= b.off_hi;
		pin_ch.has_pin         <= b.has_pin;
		pin_ch.first_of_net    <= b.first_net;
		pin_ch.last_of_net     <= b.last_net;
		pin_ch.net_low_bound   <= b.bound_lo;
		pin_ch.net_high_bound  <= b.bound_hi;
		pin_ch.net_weight      <= b.weight;
		pin_ch.first_of_pass   <= b.first_pass;
		pin_ch.valid           <= 1'b1;
		do @(posedge clk); while (!pin_ch.ready);
		step_bounding_box(b, emits, predicted);
		if (emits) begin
			if (use_typed) begin
				predicted = typed_want;
			end
			cost_expected_q = {cost_expected_q, predicted};
			pending++;
		end
		beats_sent++;
		if (beats_sent % 32 == 0) begin
			quiet_source = ($urandom_range(0, 3) == 0);
		end
	endtask

	// Drop valid and hold off until every queued net result has been seen.
	task automatic hold_until_drained();
		pin_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random ready stalls, one long hold-off, field-by-field check.
	// ------------------------------------------------------------------------
	initial begin : cost_sink
		int        stall;
		net_cost_t got;
		net_cost_t want;
		cost_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// the long hold lets the core fill every stage and push back on pins
			if (beats_taken == LONG_HOLD_AT) begin
				stall = LONG_HOLD_CYCLES;
			end else if (quiet_sink) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 17);
			end
			if (stall > 0) begin
				cost_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cost_ch.ready <= 1'b1;
			do @(posedge clk); while (!cost_ch.valid);
			got = '{cost_ch.net_cost, cost_ch.running_total, cost_ch.low_cell_index,
				cost_ch.low_found, cost_ch.high_cell_index, cost_ch.high_found};
			if (cost_expected_q.size() == 0) begin
				log_miss($sformatf("result beat %0d with no net pending", beats_taken));
			end else begin
				want = cost_expected_q.pop_front();
				pending--;
				if (got.cost !== want.cost)
					log_miss($sformatf("beat %0d net_cost %0d, want %0d",
						beats_taken, got.cost, want.cost));
				if (got.total !== want.total)
					log_miss($sformatf("beat %0d running_total %0d, want %0d",
						beats_taken, got.total, want.total));
				if (got.low_cell !== want.low_cell)
					log_miss($sformatf("beat %0d low_cell_index %h, want %h",
						beats_taken, got.low_cell, want.low_cell));
				if (got.low_found !== want.low_found)
					log_miss($sformatf("beat %0d low_found %b, want %b",
						beats_taken, got.low_found, want.low_found));
				if (got.high_cell !== want.high_cell)
					log_miss($sformatf("beat %0d high_cell_index %h, want %h",
						beats_taken, got.high_cell, want.high_cell));
				if (got.high_found !== want.high_found)
					log_miss($sformatf("beat %0d high_found %b, want %b",
						beats_taken, got.high_found, want.high_found));
			end
			beats_taken++;
			if (beats_taken % 24 == 0) begin
				quiet_sink = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Pin source: directed table, random nets, end of run.
	// ------------------------------------------------------------------------
	initial begin : pin_source
		stim_row_t directed_rows [$];
		pin_beat_t b;
		int        counted;
		int        len;
		bit        paused_mid;

		pin_ch.valid           <= 1'b0;
		pin_ch.cell_position   <= '0;
		pin_ch.cell_index      <= '0;
		pin_ch.pin_low_offset  <= '0;
		pin_ch.pin_high_offset <= '0;
		pin_ch.has_pin         <= 1'b0;
		pin_ch.first_of_net    <= 1'b0;
		pin_ch.last_of_net     <= 1'b0;
		pin_ch.net_low_bound   <= '0;
		pin_ch.net_high_bound  <= '0;
		pin_ch.net_weight      <= '0;
		pin_ch.first_of_pass   <= 1'b0;
		arst_n                 <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fields: position, cell, off_lo, off_hi, has_pin, first, last,
		//         bound_lo, bound_hi, weight, first_of_pass.
		// Typed results: cost, total, low cell, low found, high cell, high found.
		directed_rows = '{
			// pinless last beat straight after reset: empty box, zero weight
			'{'{32'sh7FFF_FFFF, 16'hFFFF, 21'sd7, -21'sd7, 1'b0, 1'b0, 1'b1,
				32'sd0, 32'sd0, 16'hFFFF, 1'b0},
				1'b1, '{50'd0, 63'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
			// pin before any first beat works on the reset box; weight still zero
			'{'{32'sd100, 16'h1234, -21'sd5, 21'sd5, 1'b1, 1'b0, 1'b1,
				32'sd0, 32'sd0, 16'h0000, 1'b0},
				1'b1, '{50'd0, 63'd0, 16'h0000, 1'b0, 16'h1234, 1'b1}},
			// first, pin and last in one beat: seed then compare, 14 * 1.0
			'{'{32'sd10, 16'h00A5, -21'sd3, 21'sd4, 1'b1, 1'b1, 1'b1,
				32'sd0, 32'sd0, 16'h0100, 1'b1},
				1'b1, '{50'd3584, 63'd3584, 16'h0000, 1'b0, 16'h00A5, 1'b1}},
			// inverted fixed extent: negative span costs nothing
			'{'{32'sd0, 16'h0000, 21'sd0, 21'sd0, 1'b0, 1'b1, 1'b1,
				32'sd100, -32'sd100, 16'hFFFF, 1'b0},
				1'b1, '{50'd0, 63'd3584, 16'h0000, 1'b0, 16'h0000, 1'b0}},
			// pin edges tie the fixed bounds: strict compare keeps both unfound
			'{'{32'sd50, 16'hBEEF, 21'sd0, 21'sd0, 1'b1, 1'b1, 1'b1,
				32'sd50, 32'sd50, 16'h0200, 1'b0},
				1'b1, '{50'd0, 63'd3584, 16'h0000, 1'b0, 16'h0000, 1'b0}},
			// five-beat net with ties and a pinless beat in the middle
			'{'{-32'sd1000, 16'h0001, -21'sd10, 21'sd10, 1'b1, 1'b1, 1'b0,
				-32'sd500, 32'sd500, 16'h0180, 1'b0}, 1'b0, '0},
			'{'{32'sd2000, 16'h0002, -21'sd3, 21'sd0, 1'b1, 1'b0, 1'b0,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			'{'{-32'sd1000, 16'h0003, -21'sd10, 21'sd10, 1'b1, 1'b0, 1'b0,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			'{'{32'sh8000_0000, 16'h0007, 21'sh10_0000, 21'sh0F_FFFF, 1'b0, 1'b0, 1'b0,
				32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0}, 1'b0, '0},
			'{'{32'sd1990, 16'h0004, 21'sd0, 21'sd10, 1'b1, 1'b0, 1'b1,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			// widest box from extreme positions and offsets, full weight
			'{'{32'sh8000_0000, 16'hFFFF, 21'sh10_0000, 21'sh0F_FFFF, 1'b1, 1'b1, 1'b0,
				32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b1}, 1'b0, '0},
			'{'{32'sh7FFF_FFFF, 16'h8000, 21'sh0F_FFFF, 21'sh0F_FFFF, 1'b1, 1'b0, 1'b1,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			// clear the total from a beat that is neither first nor last
			'{'{32'sd0, 16'h0000, 21'sd0, 21'sd0, 1'b0, 1'b0, 1'b0,
				32'sd0, 32'sd0, 16'h0000, 1'b1}, 1'b0, '0},
			'{'{32'sd0, 16'h0000, 21'sd0, 21'sd0, 1'b0, 1'b1, 1'b1,
				32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0}, 1'b0, '0},
			// zero weight on a wide pin box
			'{'{32'sd0, 16'h5A5A, 21'sh10_0000, 21'sh0F_FFFF, 1'b1, 1'b1, 1'b1,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			// lone last beat keeps working on the previous net's box
			'{'{32'sd0, 16'h0F0F, 21'sd0, 21'sd0, 1'b1, 1'b0, 1'b1,
				32'sd0, 32'sd0, 16'h0000, 1'b0}, 1'b0, '0},
			// smallest nonzero weight, new pass
			'{'{32'sd0, 16'h0000, 21'sd0, 21'sd0, 1'b0, 1'b1, 1'b1,
				-32'sd1, 32'sd1, 16'h0001, 1'b1},
				1'b1, '{50'd2, 63'd2, 16'h0000, 1'b0, 16'h0000, 1'b0}},
			// open a net, then reseed it before its last beat: owners drop
			'{'{32'sd5000, 16'h1111, 21'sd0, 21'sd0, 1'b1, 1'b1, 1'b0,
				32'sd0, 32'sd0, 16'h0100, 1'b0}, 1'b0, '0},
			'{'{32'sd0, 16'h2222, 21'sd0, 21'sd0, 1'b0, 1'b1, 1'b1,
				32'sd10, 32'sd20, 16'h0100, 1'b0},
				1'b1, '{50'd2560, 63'd2562, 16'h0000, 1'b0, 16'h0000, 1'b0}}
		};
		foreach (directed_rows[i]) begin
			offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
		end
		hold_until_drained();

		// Random nets: mostly well-formed with random content, some flag noise.
		counted    = 0;
		paused_mid = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			if (!paused_mid && counted >= RANDOM_ITEMS / 2) begin
				hold_until_drained();
				paused_mid = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				b = random_beat();
				offer_beat(b, 1'b0, '0);
				if (b.has_pin || b.first_net || b.last_net || b.first_pass)
					counted++;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
				for (int k = 0; k < len; k++) begin
					b = random_beat();
					b.first_net  = (k == 0);
					b.last_net   = (k == len - 1);
					b.has_pin    = ($urandom_range(0, 7) != 0);
					b.first_pass = (k == 0 && $urandom_range(0, 7) == 0) ||
						($urandom_range(0, 29) == 0);
					offer_beat(b, 1'b0, '0);
					if (b.has_pin || b.first_net || b.last_net || b.first_pass)
						counted++;
				end
			end
		end

		// Wait out the pipeline so a stray result beat still gets caught.
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_count == 0) begin
			$display("[net_bounding_box_wirelength_core] OK");
		end else begin
			$display("[net_bounding_box_wirelength_core] ERROR");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("[net_bounding_box_wirelength_core] ERROR");
		$finish;
	end

endmodule
